>>> hdl/rbb_pkg.sv
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared constants and controller/datapath handshake structs of the RGB
// box blur.
// ----------------------------------------------------------------------------
package rbb_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUR_RADIUS  = 2'd2;

    // Register field widths and reset values
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;
    localparam int RADIUS_W = 3;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd768;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 3'd1;
    localparam int MAX_HEIGHT = 4096;

    // Linear raster index (frame size plus flush lag)
    localparam int LIN_W = 25;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch the incoming item
        logic advance_in;  // store pixel, step input position
        logic win_start;   // reset window counters and sums
        logic issue;       // issue one window read
        logic div_load;    // load dividers with the sums
        logic div_step;    // one divider iteration
        logic out_load;    // load output register, step emit position
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_frame;
        logic is_pixel;
        logic emit_due;
        logic win_last;
        logic pipe_empty;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

>>> hdl/rbb_if.sv
// ----------------------------------------------------------------------------
// rbb_if
// Stream channels of the RGB box blur: pixel input and blurred output.
// ----------------------------------------------------------------------------
interface rbb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       is_pixel;

    modport source (output valid, red_in, green_in, blue_in, is_pixel, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, is_pixel, output ready);
endinterface

interface rbb_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [9:0]  out_column;
    logic [11:0] out_row;
    logic        frame_last;

    modport source (output valid, red_out, green_out, blue_out, out_column, out_row,
                    frame_last, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, out_column, out_row,
                    frame_last, output ready);
endinterface

>>> hdl/rbb_ctrl.sv
// ----------------------------------------------------------------------------
// rbb_ctrl
// Sequencer of the box blur: store, emit check, window walk, divide, output.
// ----------------------------------------------------------------------------
module rbb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  rbb_pkg::t_status i_st,
    output rbb_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_WRITE, S_CHECK, S_SUM, S_DRAIN, S_DIV, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.capture = i_in_valid && r_in_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) n_state = S_WRITE;
            end
            S_WRITE: begin
                // drain item inside the frame is dropped
                if (i_st.in_frame && !i_st.is_pixel) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.advance_in = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_st.emit_due) begin
                    o_cmd.win_start = 1'b1;
                    n_state = S_SUM;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SUM: begin
                o_cmd.issue = 1'b1;
                if (i_st.win_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (i_st.pipe_empty) begin
                    o_cmd.div_load = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_st.div_done) n_state = S_OUT;
                else o_cmd.div_step = 1'b1;
            end
            S_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

>>> hdl/rbb_datapath.sv
// ----------------------------------------------------------------------------
// rbb_datapath
// Line store, raster counters, window read pipeline, sum accumulators,
// restoring dividers and the output register of the box blur.
// ----------------------------------------------------------------------------
module rbb_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rbb_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rbb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [7:0]                          i_red,
    input  logic [7:0]                          i_green,
    input  logic [7:0]                          i_blue,
    input  logic                                i_is_pixel,
    input  logic                                i_out_ready,
    input  rbb_pkg::t_cmd                       i_cmd,
    output rbb_pkg::t_status                    o_st,
    output logic                                o_out_valid,
    output logic [7:0]                          o_red,
    output logic [7:0]                          o_green,
    output logic [7:0]                          o_blue,
    output logic [9:0]                          o_column,
    output logic [11:0]                         o_row,
    output logic                                o_frame_last
);

    localparam int DEPTH    = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
    localparam int AW       = $clog2(DEPTH);
    localparam int RW       = $clog2(MAX_RADIUS + 1);
    localparam int OW       = RW + 1;
    localparam int AREA_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int AREAW    = $clog2(AREA_MAX + 1);
    localparam int SW       = 8 + AREAW;
    localparam int CW       = $clog2(SW + 1);
    localparam int DW       = (AW + 2 > 13 + OW) ? AW + 2 : 13 + OW;
    localparam int WMAX     = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
    localparam int WW       = rbb_pkg::WIDTH_W;
    localparam int HW       = rbb_pkg::HEIGHT_W;
    localparam int LW       = rbb_pkg::LIN_W;

    // Configuration registers
    logic [WW-1:0]               r_cfg_w;
    logic [HW-1:0]               r_cfg_h;
    logic [rbb_pkg::RADIUS_W-1:0] r_cfg_r;
    logic                        restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= rbb_pkg::WIDTH_RST;
            r_cfg_h <= rbb_pkg::HEIGHT_RST;
            r_cfg_r <= rbb_pkg::RADIUS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rbb_pkg::CFG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data[WW-1:0];
                rbb_pkg::CFG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data[HW-1:0];
                rbb_pkg::CFG_BLUR_RADIUS:  r_cfg_r <= i_cfg_data[rbb_pkg::RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    assign restart = i_cfg_we && (i_cfg_idx == rbb_pkg::CFG_IMAGE_WIDTH ||
                                  i_cfg_idx == rbb_pkg::CFG_IMAGE_HEIGHT ||
                                  i_cfg_idx == rbb_pkg::CFG_BLUR_RADIUS);

    // Clamped geometry and derived frame constants, registered
    logic [WW-1:0] w_c, r_w;
    logic [HW-1:0] h_c, r_h;
    logic [RW-1:0] rad_c, r_rad;
    logic [LW-1:0] r_total, r_lag;
    logic [AREAW-1:0] r_area;
    logic [RW:0]   side_c;
    logic [WW-1:0] lag_min;

    always_comb begin
        if (r_cfg_w == '0)               w_c = WW'(1);
        else if (r_cfg_w > WW'(WMAX))    w_c = WW'(WMAX);
        else                             w_c = r_cfg_w;
        if (r_cfg_h == '0)                         h_c = HW'(1);
        else if (r_cfg_h > HW'(rbb_pkg::MAX_HEIGHT)) h_c = HW'(rbb_pkg::MAX_HEIGHT);
        else                                       h_c = r_cfg_h;
        if (32'(r_cfg_r) > MAX_RADIUS)   rad_c = RW'(MAX_RADIUS);
        else                             rad_c = RW'(r_cfg_r);
        side_c  = {rad_c, 1'b1};
        lag_min = (WW'(rad_c) < w_c - WW'(1)) ? WW'(rad_c) : w_c - WW'(1);
    end

    always_ff @(posedge i_clk) begin
        r_w     <= w_c;
        r_h     <= h_c;
        r_rad   <= rad_c;
        r_total <= LW'(w_c) * LW'(h_c);
        r_lag   <= LW'(rad_c) * LW'(w_c) + LW'(lag_min);
        r_area  <= AREAW'(side_c) * AREAW'(side_c);
    end

    // Captured item
    logic [23:0] r_pix;
    logic        r_is_pixel;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pix      <= {i_blue, i_green, i_red};
            r_is_pixel <= i_is_pixel;
        end
    end

    // Raster positions
    logic [LW-1:0] r_in_lin, r_em_lin;
    logic [AW-1:0] r_wr_ptr, r_em_ptr;
    logic [WW-1:0] r_em_col;
    logic [HW-1:0] r_em_row;
    logic          in_frame, frame_end;

    assign in_frame  = r_in_lin < r_total;
    assign frame_end = (r_em_lin + LW'(1)) == r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart || (i_cmd.out_load && frame_end)) begin
            r_in_lin <= '0;
            r_wr_ptr <= '0;
            r_em_lin <= '0;
            r_em_ptr <= '0;
            r_em_col <= '0;
            r_em_row <= '0;
        end else begin
            if (i_cmd.advance_in) begin
                r_in_lin <= r_in_lin + LW'(1);
                if (in_frame) begin
                    r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_em_lin <= r_em_lin + LW'(1);
                r_em_ptr <= (r_em_ptr == AW'(DEPTH - 1)) ? '0 : r_em_ptr + AW'(1);
                if (r_em_col + WW'(1) >= r_w) begin
                    r_em_col <= '0;
                    r_em_row <= r_em_row + HW'(1);
                end else begin
                    r_em_col <= r_em_col + WW'(1);
                end
            end
        end
    end

    // Window counters
    logic signed [OW-1:0] r_dy, r_dx;
    logic signed [OW-1:0] rad_s;
    logic                 win_last;

    assign rad_s    = $signed({1'b0, r_rad});
    assign win_last = (r_dy == rad_s) && (r_dx == rad_s);

    always_ff @(posedge i_clk) begin
        if (i_cmd.win_start) begin
            r_dy <= -rad_s;
            r_dx <= -rad_s;
        end else if (i_cmd.issue) begin
            if (r_dx == rad_s) begin
                r_dx <= -rad_s;
                r_dy <= r_dy + OW'(1);
            end else begin
                r_dx <= r_dx + OW'(1);
            end
        end
    end

    // Read stage 1: clamp the offsets to the image and form the raster offset
    logic signed [HW+1:0] ey, dyc_w;
    logic signed [WW+1:0] ex, dxc_w;
    logic signed [OW-1:0] dyc, dxc;
    logic signed [DW-1:0] r_off;
    logic                 r_v1, r_v2, r_v3;

    always_comb begin
        ey = $signed({2'b00, r_em_row}) + (HW+2)'(r_dy);
        ex = $signed({2'b00, r_em_col}) + (WW+2)'(r_dx);
        if (ey < 0)
            dyc_w = -$signed({2'b00, r_em_row});
        else if (ey > $signed({2'b00, r_h}) - (HW+2)'(1))
            dyc_w = $signed({2'b00, r_h}) - (HW+2)'(1) - $signed({2'b00, r_em_row});
        else
            dyc_w = (HW+2)'(r_dy);
        if (ex < 0)
            dxc_w = -$signed({2'b00, r_em_col});
        else if (ex > $signed({2'b00, r_w}) - (WW+2)'(1))
            dxc_w = $signed({2'b00, r_w}) - (WW+2)'(1) - $signed({2'b00, r_em_col});
        else
            dxc_w = (WW+2)'(r_dx);
        dyc = OW'(dyc_w);
        dxc = OW'(dxc_w);
    end

    always_ff @(posedge i_clk) begin
        r_off <= DW'(dyc) * DW'($signed({1'b0, r_w})) + DW'(dxc);
    end

    // Read stage 2: circular store address
    logic signed [DW-1:0] addr_raw;
    logic [AW-1:0]        r_addr;

    always_comb begin
        addr_raw = DW'($signed({1'b0, r_em_ptr})) + r_off;
        if (addr_raw < 0)
            addr_raw = addr_raw + DW'(DEPTH);
        else if (addr_raw >= DW'(DEPTH))
            addr_raw = addr_raw - DW'(DEPTH);
    end

    always_ff @(posedge i_clk) begin
        r_addr <= AW'(addr_raw);
    end

    // Line store: one write port, one registered read port
    logic [23:0] r_store [DEPTH];
    logic [23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.advance_in && in_frame) r_store[r_wr_ptr] <= r_pix;
        r_rdata <= r_store[r_addr];
    end

    // Pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Channel sums
    logic [SW-1:0] r_sum [3];

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.win_start)
                r_sum[c] <= '0;
            else if (r_v3)
                r_sum[c] <= r_sum[c] + SW'(r_rdata[8*c +: 8]);
        end
    end

    // Restoring dividers, one quotient bit per step
    logic [AREAW:0]  r_rem [3];
    logic [SW-1:0]   r_quo [3];
    logic [CW-1:0]   r_div_cnt;
    logic [AREAW:0]  shifted [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            shifted[c] = {r_rem[c][AREAW-1:0], r_quo[c][SW-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_load) begin
            r_div_cnt <= CW'(SW);
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.div_load) begin
                r_rem[c] <= '0;
                r_quo[c] <= r_sum[c];
            end else if (i_cmd.div_step) begin
                if (shifted[c] >= (AREAW+1)'(r_area)) begin
                    r_rem[c] <= shifted[c] - (AREAW+1)'(r_area);
                    r_quo[c] <= {r_quo[c][SW-2:0], 1'b1};
                end else begin
                    r_rem[c] <= shifted[c];
                    r_quo[c] <= {r_quo[c][SW-2:0], 1'b0};
                end
            end
        end
    end

    // Output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_red        <= r_quo[0][7:0];
            o_green      <= r_quo[1][7:0];
            o_blue       <= r_quo[2][7:0];
            o_column     <= r_em_col[9:0];
            o_row        <= r_em_row[11:0];
            o_frame_last <= frame_end;
        end
    end

    assign o_out_valid = r_out_valid;

    // Status
    always_comb begin
        o_st.in_frame   = in_frame;
        o_st.is_pixel   = r_is_pixel;
        o_st.emit_due   = (r_em_lin < r_total) && (r_in_lin > r_em_lin + r_lag);
        o_st.win_last   = win_last;
        o_st.pipe_empty = !(r_v1 || r_v2 || r_v3);
        o_st.div_done   = (r_div_cnt == '0);
        o_st.out_free   = !r_out_valid || i_out_ready;
    end

endmodule

>>> hdl/rgb_box_blur_clamped_edges.sv
// Sequence: an item that completes a window gives its result after one line
//   store read per window pixel, then a restoring divide of one bit per cycle;
//   other items give no result.
// Throughput: one item at a time; the next item waits for the window reads, the divide and a free output register.
// Reset: synchronous, active low; registers return to 1024 x 768, radius 1,
//   positions to zero. The line store is not cleared.
// ----------------------------------------------------------------------------
// rgb_box_blur_clamped_edges
// Streaming RGB box blur with edge clamping, built from a sequencer and a
// datapath with a circular line store.
// ----------------------------------------------------------------------------
module rgb_box_blur_clamped_edges #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rbb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rbb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rbb_in_if.sink                         i_pix,
    rbb_out_if.source                      o_pix
);

    rbb_pkg::t_cmd    cmd;
    rbb_pkg::t_status st;

    rbb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    rbb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_red        (i_pix.red_in),
        .i_green      (i_pix.green_in),
        .i_blue       (i_pix.blue_in),
        .i_is_pixel   (i_pix.is_pixel),
        .i_out_ready  (o_pix.ready),
        .i_cmd        (cmd),
        .o_st         (st),
        .o_out_valid  (o_pix.valid),
        .o_red        (o_pix.red_out),
        .o_green      (o_pix.green_out),
        .o_blue       (o_pix.blue_out),
        .o_column     (o_pix.out_column),
        .o_row        (o_pix.out_row),
        .o_frame_last (o_pix.frame_last)
    );

endmodule

>>> hdl/rbb_checker.sv
// ----------------------------------------------------------------------------
// rbb_checker
// Port-level checks of the box blur, bound to the top level.
// ----------------------------------------------------------------------------
module rbb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [23:0] i_out_rgb
);

    // One item in flight: a transfer closes the input until it is processed
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready stayed high after a transfer");

    // Nothing to show right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_rgb))
        else $error("result changed while stalled");

endmodule

bind rgb_box_blur_clamped_edges rbb_checker u_rbb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_rgb   ({o_pix.blue_out, o_pix.green_out, o_pix.red_out})
);

>>> dv/rgb_box_blur_clamped_edges_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_box_blur_clamped_edges_tb
// Self-checking bench for the streaming RGB box blur. Frames of random size
// and radius are pushed through the pixel channel, followed by drain items
// that flush the last rows. A behavioral blur tracks the raster positions
// and the line store and predicts each windowed mean. Every output transfer
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rgb_box_blur_clamped_edges_tb;

    localparam int MAXW        = 1024;
    localparam int MAXR        = 7;
    localparam int STORE_DEPTH = 2 * MAXR * MAXW + 2 * MAXR + 1;
    localparam int SETTLE      = 300;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [9:0]  col;
        logic [11:0] row;
        logic        last;
    } t_blur_px;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [rbb_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [rbb_pkg::CFG_DATA_W-1:0] i_cfg_data;

    rbb_in_if  pix_in ();
    rbb_out_if pix_out ();

    rgb_box_blur_clamped_edges u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    // Blur state mirrored by the bench
    logic [23:0] line_store [STORE_DEPTH];
    int unsigned reg_w, reg_h, reg_r;
    int unsigned in_col, in_row, em_col, em_row;
    t_blur_px    pending_px[$];

    int unsigned send_idle, recv_idle;
    int unsigned n_items, n_results, n_frames, n_errors;
    int unsigned n_cycles = 0;

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, pending_px.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned clamp_idx(int v, int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_positions();
        in_col = 0;
        in_row = 0;
        em_col = 0;
        em_row = 0;
    endfunction

    // Advance the blur by one accepted item; queue the mean it produces
    function automatic void blur_accept(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                                        logic pix);
        int unsigned w, h, r, total, lag, in_lin, em_lin, area;
        int unsigned sr, sg, sb, yr, xc;
        logic [23:0] v;
        t_blur_px px;
        w = clamp_u(reg_w, 1, MAXW);
        h = clamp_u(reg_h, 1, rbb_pkg::MAX_HEIGHT);
        r = clamp_u(reg_r, 0, MAXR);
        total = w * h;
        lag = r * w + ((r < w - 1) ? r : w - 1);
        in_lin = in_row * w + in_col;
        em_lin = em_row * w + em_col;
        if (in_lin < total) begin
            if (!pix) return;
            line_store[in_lin % STORE_DEPTH] = {blue, green, red};
        end
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        in_lin++;
        if (em_lin >= total || in_lin < em_lin + lag + 1) return;

        sr = 0;
        sg = 0;
        sb = 0;
        for (int dy = -int'(r); dy <= int'(r); dy++) begin
            yr = clamp_idx(int'(em_row) + dy, int'(h) - 1);
            for (int dx = -int'(r); dx <= int'(r); dx++) begin
                xc = clamp_idx(int'(em_col) + dx, int'(w) - 1);
                v = line_store[(yr * w + xc) % STORE_DEPTH];
                sr += v[7:0];
                sg += v[15:8];
                sb += v[23:16];
            end
        end
        area = (2 * r + 1) * (2 * r + 1);
        px.red   = 8'(sr / area);
        px.green = 8'(sg / area);
        px.blue  = 8'(sb / area);
        px.col   = 10'(em_col);
        px.row   = 12'(em_row);
        px.last  = (em_lin + 1 == total);
        pending_px.push_back(px);
        if (em_lin + 1 == total) begin
            restart_positions();
            n_frames++;
        end else begin
            em_col++;
            if (em_col >= w) begin
                em_col = 0;
                em_row++;
            end
        end
    endfunction

    // Output side: random ready, checked at the rising edge
    always @(negedge i_clk) begin
        pix_out.ready = ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        t_blur_px got, want;
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            got = '{pix_out.red_out, pix_out.green_out, pix_out.blue_out,
                    pix_out.out_column, pix_out.out_row, pix_out.frame_last};
            n_results++;
            if (pending_px.size() == 0) begin
                $display("%0t: unexpected output, expected none, actual %p", $time, got);
                n_errors++;
            end else begin
                want = pending_px.pop_front();
                if (got !== want) begin
                    $display("%0t: output mismatch, expected %p, actual %p", $time, want, got);
                    n_errors++;
                end
            end
        end
    end

    // One input transfer; starts and ends at a falling edge
    task automatic send_item(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                             logic pix);
        while ($urandom_range(99) < send_idle) begin
            pix_in.valid = 1'b0;
            @(negedge i_clk);
        end
        pix_in.valid    = 1'b1;
        pix_in.red_in   = red;
        pix_in.green_in = green;
        pix_in.blue_in  = blue;
        pix_in.is_pixel = pix;
        do @(posedge i_clk); while (!pix_in.ready);
        blur_accept(red, green, blue, pix);
        n_items++;
        @(negedge i_clk);
        pix_in.valid = 1'b0;
    endtask

    task automatic send_rand(logic pix);
        send_item(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                  pix);
    endtask

    // Wait until every mean has arrived and the block has gone quiet
    task automatic wait_idle();
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [rbb_pkg::CFG_IDX_W-1:0] idx,
                             logic [rbb_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        case (idx)
            rbb_pkg::CFG_IMAGE_WIDTH:  reg_w = data & 13'h7FF;
            rbb_pkg::CFG_IMAGE_HEIGHT: reg_h = data;
            rbb_pkg::CFG_BLUR_RADIUS:  reg_r = data & 13'h7;
            default: ;
        endcase
        restart_positions();
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_frame(logic [rbb_pkg::CFG_DATA_W-1:0] w,
                             logic [rbb_pkg::CFG_DATA_W-1:0] h,
                             logic [rbb_pkg::CFG_DATA_W-1:0] r);
        write_reg(rbb_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(rbb_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(rbb_pkg::CFG_BLUR_RADIUS, r);
    endtask

    // Reset geometry: 1024 x 768, radius 1, so a short burst gives nothing
    task automatic test_reset_defaults();
        send_item(8'hFF, 8'h00, 8'hFF, 1'b1);
        repeat (15) send_rand(1'b1);
        wait_idle();
    endtask

    // 4 x 3, radius 1, with idle drain, drains inside the frame, pixels during
    // the flush and channel extremes
    task automatic test_small_frame();
        set_frame(13'd4, 13'd3, 13'd1);
        send_rand(1'b0);
        send_item(8'h00, 8'h00, 8'h00, 1'b1);
        send_item(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_item(8'hFF, 8'h00, 8'h55, 1'b1);
        send_rand(1'b0);
        send_item(8'h00, 8'hFF, 8'hAA, 1'b1);
        repeat (8) send_rand(1'b1);
        send_rand(1'b1);
        repeat (4) send_rand(1'b0);
        send_rand(1'b0);
        send_rand(1'b0);
        wait_idle();
    endtask

    // Register extremes: clamped width and height, zero and maximum radius
    task automatic test_register_extremes();
        // width 0 -> 1, height 1, radius 7: one pixel, seven drains
        set_frame(13'd0, 13'd1, 13'd7);
        send_item(8'hFF, 8'hFF, 8'hFF, 1'b1);
        repeat (7) send_rand(1'b0);
        wait_idle();
        // width 2047 -> 1024, height 8191 -> 4096, radius 0: partial frame
        set_frame(13'h1FFF, 13'h1FFF, 13'h1FF8);
        repeat (20) send_rand(1'b1);
        wait_idle();
        // full width, radius 7: nothing due yet, restarted by the next write
        write_reg(rbb_pkg::CFG_BLUR_RADIUS, 13'd7);
        repeat (20) send_rand(1'b1);
        wait_idle();
        // height 0 -> 1 with width 3, radius 2
        set_frame(13'd3, 13'd0, 13'd2);
        repeat (3) send_rand(1'b1);
        repeat (5) send_rand(1'b0);
        wait_idle();
    endtask

    // Random frames, most complete, some cut short
    task automatic test_random_frames(int unsigned n_target);
        int unsigned w, h, r, total, lag, stop_at, start;
        start = n_items;
        while (n_items - start < n_target) begin
            w = ($urandom_range(9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            h = ($urandom_range(9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 12);
            r = $urandom_range(0, 7);
            set_frame(13'(w | ($urandom_range(3) << 11)), 13'(h),
                      13'(r | ($urandom_range(1023) << 3)));
            total = w * h;
            lag = r * w + ((r < w - 1) ? r : w - 1);
            stop_at = ($urandom_range(9) == 0) ? $urandom_range(0, total - 1) : total;
            if ($urandom_range(9) == 0) send_rand(1'b0);
            for (int unsigned k = 0; k < stop_at; k++) begin
                if ($urandom_range(19) == 0) send_rand(1'b0);
                send_rand(1'b1);
            end
            if (stop_at == total) begin
                for (int unsigned k = 0; k < lag; k++)
                    send_rand(($urandom_range(9) == 0) ? 1'b1 : 1'b0);
            end
            wait_idle();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = rbb_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data      = '0;
        pix_in.valid    = 1'b0;
        pix_in.red_in   = '0;
        pix_in.green_in = '0;
        pix_in.blue_in  = '0;
        pix_in.is_pixel = 1'b0;
        pix_out.ready   = 1'b0;
        n_items   = 0;
        n_results = 0;
        n_frames  = 0;
        n_errors  = 0;
        reg_w = rbb_pkg::WIDTH_RST;
        reg_h = rbb_pkg::HEIGHT_RST;
        reg_r = rbb_pkg::RADIUS_RST;
        restart_positions();
        send_idle = 19;
        recv_idle = 52;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_small_frame();
        test_register_extremes();
        test_random_frames(450);
        send_idle = 52;
        recv_idle = 19;
        test_random_frames(450);
        send_idle = 0;
        recv_idle = 0;
        test_random_frames(450);

        wait_idle();
        $display("Sent %0d items, checked %0d blurred pixels, %0d frames completed",
                 n_items, n_results, n_frames);
        $display("Covered radius 0..7, clamped geometry, drains and flush-time pixels");
        if (n_errors == 0 && pending_px.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
